// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL. All are clocked on i_clk and
// switched off while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/ifeu_pkg.sv =====
`timescale 1ns / 1ps

package ifeu_pkg;

    localparam int XLEN      = 64;
    localparam int IMM_W     = 48;
    localparam int REG_W     = 5;
    localparam int OP_W      = 5;
    localparam int REG_COUNT = 32;

    // Data memory size in bytes; a power of two from 64 up to 16M.
    localparam int MEM_BYTES = 65536;
    localparam int MEM_AW    = $clog2(MEM_BYTES);
    // Two banks of 8-byte rows: even rows in bank 0, odd rows in bank 1.
    localparam int BANK_ROWS = MEM_BYTES / 16;
    localparam int BANK_AW   = $clog2(BANK_ROWS);

    typedef enum logic [OP_W-1:0] {
        OP_ADDI  = 5'd0,
        OP_ADDIU = 5'd1,
        OP_ANDI  = 5'd2,
        OP_ORI   = 5'd3,
        OP_XORI  = 5'd4,
        OP_SLTI  = 5'd5,
        OP_SLTIU = 5'd6,
        OP_BEQ   = 5'd7,
        OP_BNE   = 5'd8,
        OP_LB    = 5'd9,
        OP_LBU   = 5'd10,
        OP_LH    = 5'd11,
        OP_LHU   = 5'd12,
        OP_LW    = 5'd13,
        OP_LUI   = 5'd14,
        OP_SB    = 5'd15,
        OP_SH    = 5'd16,
        OP_SW    = 5'd17
    } t_op;

    function automatic logic f_writes_reg(input t_op op);
        logic res;
        unique case (op)
            OP_ADDI, OP_ADDIU, OP_ANDI, OP_ORI, OP_XORI, OP_SLTI, OP_SLTIU,
            OP_LB, OP_LBU, OP_LH, OP_LHU, OP_LW, OP_LUI: res = 1'b1;
            default: res = 1'b0;
        endcase
        return res;
    endfunction

    function automatic logic f_is_load(input t_op op);
        logic res;
        unique case (op)
            OP_LB, OP_LBU, OP_LH, OP_LHU, OP_LW: res = 1'b1;
            default: res = 1'b0;
        endcase
        return res;
    endfunction

    function automatic logic f_is_store(input t_op op);
        logic res;
        unique case (op)
            OP_SB, OP_SH, OP_SW: res = 1'b1;
            default: res = 1'b0;
        endcase
        return res;
    endfunction

    function automatic logic [XLEN-1:0] f_sext_imm(input logic [IMM_W-1:0] imm);
        return {{(XLEN-IMM_W){imm[IMM_W-1]}}, imm};
    endfunction

endpackage

// ===== rtl/ifeu_channels.sv =====
`timescale 1ns / 1ps

// Instruction channel.
interface ifeu_instr_if import ifeu_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   op;
    logic [REG_W-1:0]  src_reg;
    logic [REG_W-1:0]  tgt_reg;
    logic [IMM_W-1:0]  imm_bits;
    logic [XLEN-1:0]   cur_pc;

    modport source (output valid, op, src_reg, tgt_reg, imm_bits, cur_pc, input ready);
    modport sink   (input valid, op, src_reg, tgt_reg, imm_bits, cur_pc, output ready);
endinterface

// Result channel.
interface ifeu_result_if import ifeu_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              reg_written;
    logic [REG_W-1:0]  written_reg;
    logic [XLEN-1:0]   written_value;
    logic              branch_taken;
    logic [XLEN-1:0]   branch_target;

    modport source (output valid, reg_written, written_reg, written_value, branch_taken,
                    branch_target, input ready);
    modport sink   (input valid, reg_written, written_reg, written_value, branch_taken,
                    branch_target, output ready);
endinterface

// ===== rtl/immediate_format_execute_unit.sv =====
// Immediate-format execute unit for a 64-bit MIPS-style core.
// i_instr carries one instruction per beat (op, src_reg, tgt_reg, 48-bit
// immediate, pc); o_result returns exactly one beat per instruction, in order,
// with the register write (if any) and the branch outcome.
// Both channels use valid/ready; a beat moves when both are high.
// An instruction passes register read and execute, memory access, load align
// and the output register in turn. Throughput: one instruction per cycle unless
// a stage is held. A load followed directly by an instruction that reads its
// target register holds that instruction in stage 1, since the load data only
// leaves the data memory read port in the writeback stage.
// Reset: the register file reads as zero through per-register valid bits; the
// 64 KiB data memory is swept to zero, one 16-byte row pair per cycle, and
// i_instr.ready stays low during the sweep.
// Stall: a result held on o_result stalls the stages behind it; every stage
// holds until the one ahead frees up, and the input keeps accepting while
// there is an empty stage in the pipe and no load-use hold.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module immediate_format_execute_unit import ifeu_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ifeu_instr_if.sink    i_instr,
    ifeu_result_if.source o_result
);

    // ------------------------------------------------------------------
    // Storage
    // ------------------------------------------------------------------
    // Register file: two copies, one per read port, written together.
    logic [XLEN-1:0]      r_rf_a [REG_COUNT];
    logic [XLEN-1:0]      r_rf_b [REG_COUNT];
    logic [REG_COUNT-1:0] r_rf_ok;
    logic [XLEN-1:0]      r_rfa_q, r_rfb_q;
    logic                 r_rfa_ok, r_rfb_ok;

    // Data memory: two banks of 64-bit rows with byte enables.
    logic [63:0]          r_bank0 [BANK_ROWS];
    logic [63:0]          r_bank1 [BANK_ROWS];
    logic [63:0]          r_q0, r_q1;

    logic                 r_clr_busy;
    logic [BANK_AW-1:0]   r_clr_cnt;

    // ------------------------------------------------------------------
    // Pipeline registers
    // ------------------------------------------------------------------
    logic                 r_s1_v;
    t_op                  r_s1_op;
    logic [REG_W-1:0]     r_s1_rs, r_s1_rt;
    logic [IMM_W-1:0]     r_s1_imm;
    logic [XLEN-1:0]      r_s1_pc;

    logic                 r_s2_v;
    t_op                  r_s2_op;
    logic [REG_W-1:0]     r_s2_rt;
    logic [XLEN-1:0]      r_s2_val;
    logic [MEM_AW-1:0]    r_s2_addr;
    logic [XLEN-1:0]      r_s2_b;
    logic                 r_s2_taken;
    logic [XLEN-1:0]      r_s2_pc;
    logic [IMM_W-1:0]     r_s2_imm;

    logic                 r_s3_v;
    t_op                  r_s3_op;
    logic [REG_W-1:0]     r_s3_rt;
    logic [XLEN-1:0]      r_s3_val;
    logic                 r_s3_taken;
    logic [XLEN-1:0]      r_s3_target;
    logic [2:0]           r_s3_off;
    logic                 r_s3_odd;

    logic                 r_o_v;
    logic                 r_o_wr;
    logic [REG_W-1:0]     r_o_reg;
    logic [XLEN-1:0]      r_o_val;
    logic                 r_o_taken;
    logic [XLEN-1:0]      r_o_target;

    // ------------------------------------------------------------------
    // Flow control: each stage advances when the one ahead is empty or
    // moving. A load in stage 2 whose target feeds stage 1 holds stage 1.
    // ------------------------------------------------------------------
    logic w_o_free, w_s3_free, w_s2_free, w_s1_free;
    logic w_s3_adv, w_s2_adv, w_s1_adv, w_acc;
    logic w_hazard;

    assign w_o_free  = !r_o_v || o_result.ready;
    assign w_s3_adv  = r_s3_v && w_o_free;
    assign w_s3_free = !r_s3_v || w_o_free;
    assign w_s2_adv  = r_s2_v && w_s3_free;
    assign w_s2_free = !r_s2_v || w_s3_free;
    assign w_hazard  = r_s1_v && r_s2_v && f_is_load(r_s2_op) &&
                       ((r_s2_rt == r_s1_rs) || (r_s2_rt == r_s1_rt));
    assign w_s1_adv  = r_s1_v && w_s2_free && !w_hazard;
    assign w_s1_free = !r_s1_v || w_s1_adv;
    assign w_acc     = i_instr.valid && i_instr.ready;

    assign i_instr.ready = !r_clr_busy && w_s1_free;

    // ------------------------------------------------------------------
    // Register file read: re-read every cycle so a held stage 1 always sees
    // the file as of the last edge; the output stage covers that edge's write.
    // ------------------------------------------------------------------
    logic [REG_W-1:0] w_rda_addr, w_rdb_addr;
    logic             w_rf_we;
    logic [XLEN-1:0]  w_s3_val;

    assign w_rda_addr = w_s1_free ? i_instr.src_reg : r_s1_rs;
    assign w_rdb_addr = w_s1_free ? i_instr.tgt_reg : r_s1_rt;
    assign w_rf_we    = w_s3_adv && f_writes_reg(r_s3_op);

    always_ff @(posedge i_clk) begin
        if (w_rf_we) begin
            r_rf_a[r_s3_rt] <= w_s3_val;
            r_rf_b[r_s3_rt] <= w_s3_val;
        end
        r_rfa_q <= r_rf_a[w_rda_addr];
        r_rfb_q <= r_rf_b[w_rdb_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rf_ok  <= '0;
            r_rfa_ok <= 1'b0;
            r_rfb_ok <= 1'b0;
        end else begin
            if (w_rf_we) begin
                r_rf_ok[r_s3_rt] <= 1'b1;
            end
            r_rfa_ok <= r_rf_ok[w_rda_addr];
            r_rfb_ok <= r_rf_ok[w_rdb_addr];
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: operand forwarding and execute
    // ------------------------------------------------------------------
    logic             w_s2_wr, w_s3_wr;
    logic [XLEN-1:0]  w_a, w_b, w_simm, w_zimm, w_sum, w_s1_val;
    logic             w_eq, w_s1_taken;

    assign w_s2_wr = r_s2_v && f_writes_reg(r_s2_op);
    assign w_s3_wr = r_s3_v && f_writes_reg(r_s3_op);

    always_comb begin
        priority if (w_s2_wr && (r_s2_rt == r_s1_rs)) begin
            w_a = r_s2_val;
        end else if (w_s3_wr && (r_s3_rt == r_s1_rs)) begin
            w_a = w_s3_val;
        end else if (r_o_v && r_o_wr && (r_o_reg == r_s1_rs)) begin
            w_a = r_o_val;
        end else begin
            w_a = r_rfa_ok ? r_rfa_q : '0;
        end
    end

    always_comb begin
        priority if (w_s2_wr && (r_s2_rt == r_s1_rt)) begin
            w_b = r_s2_val;
        end else if (w_s3_wr && (r_s3_rt == r_s1_rt)) begin
            w_b = w_s3_val;
        end else if (r_o_v && r_o_wr && (r_o_reg == r_s1_rt)) begin
            w_b = r_o_val;
        end else begin
            w_b = r_rfb_ok ? r_rfb_q : '0;
        end
    end

    assign w_simm = f_sext_imm(r_s1_imm);
    assign w_zimm = {{(XLEN-IMM_W){1'b0}}, r_s1_imm};
    assign w_sum  = w_a + w_simm;
    assign w_eq   = (w_a == w_b);

    always_comb begin
        w_s1_val   = '0;
        w_s1_taken = 1'b0;
        unique case (r_s1_op)
            OP_ADDI, OP_ADDIU: w_s1_val = w_sum;
            OP_ANDI:  w_s1_val = w_a & w_zimm;
            OP_ORI:   w_s1_val = w_a | w_zimm;
            OP_XORI:  w_s1_val = w_a ^ w_zimm;
            OP_SLTI:  w_s1_val = {{(XLEN-1){1'b0}}, ($signed(w_a) < $signed(w_simm))};
            OP_SLTIU: w_s1_val = {{(XLEN-1){1'b0}}, (w_a < w_simm)};
            OP_BEQ:   w_s1_taken = w_eq;
            OP_BNE:   w_s1_taken = !w_eq;
            OP_LUI:   w_s1_val = {r_s1_imm[31:0], 32'h0};
            default:  w_s1_val = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Stage 2: branch target, data memory access
    // ------------------------------------------------------------------
    logic [MEM_AW-4:0]  w_row;
    logic [BANK_AW-1:0] w_row_hi;
    logic               w_odd;
    logic [2:0]         w_off;
    logic [7:0]         w_st_mask;
    logic [15:0]        w_st_be;
    logic [127:0]       w_st_wd;
    logic               w_st_we;
    logic [XLEN-1:0]    w_s2_target;

    logic [BANK_AW-1:0] w_b0_addr, w_b1_addr;
    logic [7:0]         w_b0_be, w_b1_be;
    logic [63:0]        w_b0_wd, w_b1_wd;
    logic               w_b0_we, w_b1_we;

    assign w_row       = r_s2_addr[MEM_AW-1:3];
    assign w_row_hi    = w_row[MEM_AW-4:1];
    assign w_odd       = w_row[0];
    assign w_off       = r_s2_addr[2:0];
    assign w_st_we     = w_s2_adv && f_is_store(r_s2_op);
    assign w_s2_target = r_s2_pc + XLEN'(8) + f_sext_imm(r_s2_imm);

    always_comb begin
        unique case (r_s2_op)
            OP_SB:   w_st_mask = 8'h01;
            OP_SH:   w_st_mask = 8'h0F;
            OP_SW:   w_st_mask = 8'hFF;
            default: w_st_mask = 8'h00;
        endcase
    end

    // Place the store in a 16-byte window: low half is row r, high half r+1.
    assign w_st_be = {8'h00, w_st_mask} << w_off;
    assign w_st_wd = {64'h0, r_s2_b} << {w_off, 3'b000};

    always_comb begin
        if (r_clr_busy) begin
            w_b0_addr = r_clr_cnt;
            w_b1_addr = r_clr_cnt;
            w_b0_be   = 8'hFF;
            w_b1_be   = 8'hFF;
            w_b0_wd   = '0;
            w_b1_wd   = '0;
            w_b0_we   = 1'b1;
            w_b1_we   = 1'b1;
        end else begin
            // Row r+1 of an odd row r lives in bank 0 one entry up.
            w_b0_addr = w_odd ? (w_row_hi + BANK_AW'(1)) : w_row_hi;
            w_b1_addr = w_row_hi;
            w_b0_be   = w_odd ? w_st_be[15:8]   : w_st_be[7:0];
            w_b1_be   = w_odd ? w_st_be[7:0]    : w_st_be[15:8];
            w_b0_wd   = w_odd ? w_st_wd[127:64] : w_st_wd[63:0];
            w_b1_wd   = w_odd ? w_st_wd[63:0]   : w_st_wd[127:64];
            w_b0_we   = w_st_we;
            w_b1_we   = w_st_we;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_b0_we) begin
            for (int k = 0; k < 8; k++) begin
                if (w_b0_be[k]) begin
                    r_bank0[w_b0_addr][8*k +: 8] <= w_b0_wd[8*k +: 8];
                end
            end
        end
        if (w_s2_adv) begin
            r_q0 <= r_bank0[w_b0_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_b1_we) begin
            for (int k = 0; k < 8; k++) begin
                if (w_b1_be[k]) begin
                    r_bank1[w_b1_addr][8*k +: 8] <= w_b1_wd[8*k +: 8];
                end
            end
        end
        if (w_s2_adv) begin
            r_q1 <= r_bank1[w_b1_addr];
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: load align and extend, register write
    // ------------------------------------------------------------------
    logic [127:0] w_win, w_win_sh;
    logic [63:0]  w_raw;

    assign w_win    = r_s3_odd ? {r_q0, r_q1} : {r_q1, r_q0};
    assign w_win_sh = w_win >> {r_s3_off, 3'b000};
    assign w_raw    = w_win_sh[63:0];

    always_comb begin
        unique case (r_s3_op)
            OP_LB:   w_s3_val = {{56{w_raw[7]}}, w_raw[7:0]};
            OP_LBU:  w_s3_val = {56'h0, w_raw[7:0]};
            OP_LH:   w_s3_val = {{32{w_raw[31]}}, w_raw[31:0]};
            OP_LHU:  w_s3_val = {32'h0, w_raw[31:0]};
            OP_LW:   w_s3_val = w_raw;
            default: w_s3_val = r_s3_val;
        endcase
    end

    // ------------------------------------------------------------------
    // Control state: stage valids and the memory clearing sweep
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v     <= 1'b0;
            r_s2_v     <= 1'b0;
            r_s3_v     <= 1'b0;
            r_o_v      <= 1'b0;
            r_clr_busy <= 1'b1;
            r_clr_cnt  <= '0;
        end else begin
            if (w_s1_free) begin
                r_s1_v <= w_acc;
            end
            if (w_s2_free) begin
                r_s2_v <= w_s1_adv;
            end
            if (w_s3_free) begin
                r_s3_v <= w_s2_adv;
            end
            if (w_o_free) begin
                r_o_v <= w_s3_adv;
            end
            if (r_clr_busy) begin
                r_clr_cnt <= r_clr_cnt + BANK_AW'(1);
                if (r_clr_cnt == BANK_AW'(BANK_ROWS - 1)) begin
                    r_clr_busy <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Payload: load each stage as its beat advances into it
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_s1_op  <= t_op'(i_instr.op);
            r_s1_rs  <= i_instr.src_reg;
            r_s1_rt  <= i_instr.tgt_reg;
            r_s1_imm <= i_instr.imm_bits;
            r_s1_pc  <= i_instr.cur_pc;
        end
        if (w_s1_adv) begin
            r_s2_op    <= r_s1_op;
            r_s2_rt    <= r_s1_rt;
            r_s2_val   <= w_s1_val;
            r_s2_addr  <= w_sum[MEM_AW-1:0];
            r_s2_b     <= w_b;
            r_s2_taken <= w_s1_taken;
            r_s2_pc    <= r_s1_pc;
            r_s2_imm   <= r_s1_imm;
        end
        if (w_s2_adv) begin
            r_s3_op     <= r_s2_op;
            r_s3_rt     <= r_s2_rt;
            r_s3_val    <= r_s2_val;
            r_s3_taken  <= r_s2_taken;
            r_s3_target <= r_s2_taken ? w_s2_target : '0;
            r_s3_off    <= w_off;
            r_s3_odd    <= w_odd;
        end
        if (w_s3_adv) begin
            r_o_wr     <= f_writes_reg(r_s3_op);
            r_o_reg    <= f_writes_reg(r_s3_op) ? r_s3_rt : '0;
            r_o_val    <= f_writes_reg(r_s3_op) ? w_s3_val : '0;
            r_o_taken  <= r_s3_taken;
            r_o_target <= r_s3_target;
        end
    end

    assign o_result.valid         = r_o_v;
    assign o_result.reg_written   = r_o_wr;
    assign o_result.written_reg   = r_o_reg;
    assign o_result.written_value = r_o_val;
    assign o_result.branch_taken  = r_o_taken;
    assign o_result.branch_target = r_o_target;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // A register write always lands in the output stage on the next cycle.
    `ASSERT_NEXT(a_rf_write_lands, w_rf_we, r_o_v && r_o_wr, "register write without result")
    // No instruction is in flight while the memory sweep runs.
    `ASSERT_IMPLIES(a_clear_empty, r_clr_busy, !(r_s1_v || r_s2_v || r_s3_v || r_o_v), "busy pipe during memory clear")
    // Stores never collide with the clearing sweep.
    `ASSERT_IMPLIES(a_store_after_clear, w_st_we, !r_clr_busy, "store during memory clear")
    // A load-use hold keeps the dependent instruction in stage 1.
    `ASSERT_NEXT(a_hazard_hold, w_hazard, r_s1_v && $stable(r_s1_rs), "dependent instruction lost on load-use hold")

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the immediate-format execute unit.
// The sender predicts each instruction in program order as it builds it;
// the monitor moves that prediction into the awaited queue on the input beat
// and compares each result beat against the head of that queue.
module tb_top;
    import ifeu_pkg::*;

    // Op codes the unit does not decode: no state change, all-zero result.
    localparam logic [OP_W-1:0] OP_FIRST_UNUSED = 5'd18;
    localparam logic [OP_W-1:0] OP_LAST_UNUSED  = 5'd31;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [REG_W-1:0] src_reg;
        logic [REG_W-1:0] tgt_reg;
        logic [IMM_W-1:0] imm_bits;
        logic [XLEN-1:0]  cur_pc;
    } instr_t;

    typedef struct packed {
        logic             reg_written;
        logic [REG_W-1:0] written_reg;
        logic [XLEN-1:0]  written_value;
        logic             branch_taken;
        logic [XLEN-1:0]  branch_target;
    } result_t;

    logic i_clk;
    logic i_rst_n;

    ifeu_instr_if  instr_ch ();
    ifeu_result_if result_ch ();

    immediate_format_execute_unit DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_instr  (instr_ch),
        .o_result (result_ch)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Architectural shadow state; both start at zero like the unit after reset.
    bit [XLEN-1:0] gpr [REG_COUNT];
    bit [7:0]      data_mem [MEM_BYTES];

    // Predictions for instructions driven but not yet accepted, and for
    // instructions accepted whose result beat has not come back.
    result_t issued_results [$];
    result_t awaited_results [$];
    result_t head_result;

    int unsigned errors;
    int unsigned results_checked;
    int unsigned loads_run, stores_run, branches_taken, unused_run;

    bit sender_idles;
    bit receiver_stalls;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Gather n bytes little-endian; each byte address wraps on its own.
    function automatic logic [XLEN-1:0] load_le(logic [XLEN-1:0] addr, int unsigned n);
        logic [XLEN-1:0] v;
        logic [MEM_AW-1:0] idx;
        v = '0;
        for (int unsigned k = 0; k < n; k++) begin
            idx = MEM_AW'(addr + XLEN'(k));
            v[8*k +: 8] = data_mem[idx];
        end
        return v;
    endfunction

    function automatic void store_le(logic [XLEN-1:0] addr, logic [XLEN-1:0] v,
                                     int unsigned n);
        logic [MEM_AW-1:0] idx;
        for (int unsigned k = 0; k < n; k++) begin
            idx = MEM_AW'(addr + XLEN'(k));
            data_mem[idx] = v[8*k +: 8];
        end
    endfunction

    // Execute one instruction against the shadow state and return its result.
    function automatic result_t execute_instr(instr_t ins);
        result_t r;
        logic [XLEN-1:0] a, b, simm, addr, val;
        logic wr, taken;
        a     = gpr[ins.src_reg];
        b     = gpr[ins.tgt_reg];
        simm  = {{(XLEN-IMM_W){ins.imm_bits[IMM_W-1]}}, ins.imm_bits};
        addr  = a + simm;
        val   = '0;
        wr    = 1'b0;
        taken = 1'b0;
        case (ins.op)
            OP_ADDI, OP_ADDIU: begin
                val = a + simm;
                wr  = 1'b1;
            end
            OP_ANDI: begin
                val = a & XLEN'(ins.imm_bits);
                wr  = 1'b1;
            end
            OP_ORI: begin
                val = a | XLEN'(ins.imm_bits);
                wr  = 1'b1;
            end
            OP_XORI: begin
                val = a ^ XLEN'(ins.imm_bits);
                wr  = 1'b1;
            end
            OP_SLTI: begin
                val = XLEN'($signed(a) < $signed(simm));
                wr  = 1'b1;
            end
            OP_SLTIU: begin
                val = XLEN'(a < simm);
                wr  = 1'b1;
            end
            OP_BEQ: taken = (a == b);
            OP_BNE: taken = (a != b);
            OP_LB: begin
                val = load_le(addr, 1);
                val = {{(XLEN-8){val[7]}}, val[7:0]};
                wr  = 1'b1;
            end
            OP_LBU: begin
                val = load_le(addr, 1);
                wr  = 1'b1;
            end
            OP_LH: begin
                val = load_le(addr, 4);
                val = {{(XLEN-32){val[31]}}, val[31:0]};
                wr  = 1'b1;
            end
            OP_LHU: begin
                val = load_le(addr, 4);
                wr  = 1'b1;
            end
            OP_LW: begin
                val = load_le(addr, 8);
                wr  = 1'b1;
            end
            OP_LUI: begin
                val = {ins.imm_bits[31:0], 32'b0};
                wr  = 1'b1;
            end
            OP_SB: store_le(addr, b, 1);
            OP_SH: store_le(addr, b, 4);
            OP_SW: store_le(addr, b, 8);
            default: unused_run++;
        endcase
        if (ins.op inside {OP_LB, OP_LBU, OP_LH, OP_LHU, OP_LW})
            loads_run++;
        if (ins.op inside {OP_SB, OP_SH, OP_SW})
            stores_run++;
        if (taken)
            branches_taken++;
        if (wr)
            gpr[ins.tgt_reg] = val;
        r.reg_written   = wr;
        r.written_reg   = wr ? ins.tgt_reg : '0;
        r.written_value = wr ? val : '0;
        r.branch_taken  = taken;
        r.branch_target = taken ? ins.cur_pc + XLEN'(8) + simm : '0;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Mostly a narrow register set so that hazards and reuse are frequent.
    function automatic logic [REG_W-1:0] pick_reg(int unsigned hi);
        if ($urandom_range(0, 3) != 0)
            return REG_W'($urandom_range(0, hi));
        return REG_W'($urandom_range(0, REG_COUNT - 1));
    endfunction

    // Bias toward the sign boundary, all ones, zero and small offsets.
    function automatic logic [IMM_W-1:0] random_imm();
        logic [IMM_W-1:0] v;
        case ($urandom_range(0, 7))
            0: v = '0;
            1: v = '1;
            2: v = {1'b1, {(IMM_W-1){1'b0}}};
            3: v = {1'b0, {(IMM_W-1){1'b1}}};
            4: v = IMM_W'($urandom_range(0, 255));
            5: v = '0 - IMM_W'($urandom_range(1, 256));
            default: v = IMM_W'({$urandom, $urandom});
        endcase
        return v;
    endfunction

    function automatic instr_t random_instr(int unsigned reg_hi);
        instr_t ins;
        int unsigned pick;
        logic [MEM_AW-1:0] spot;
        ins.src_reg  = pick_reg(reg_hi);
        ins.tgt_reg  = pick_reg(reg_hi);
        ins.imm_bits = random_imm();
        ins.cur_pc   = ($urandom_range(0, 7) == 0) ? '1 - XLEN'($urandom_range(0, 63))
                                                   : {$urandom, $urandom};
        pick = $urandom_range(0, 99);
        if (pick < 38) begin
            if ($urandom_range(0, 1) != 0)
                ins.op = OP_W'($urandom_range(OP_LB, OP_LW));
            else
                ins.op = OP_W'($urandom_range(OP_SB, OP_SW));
            // Steer most accesses into a small window that straddles the top
            // of memory, so loads see earlier stores and multi-byte accesses
            // wrap. Only the low address bits select the byte, so keep the
            // upper immediate bits random.
            if ($urandom_range(0, 4) != 0) begin
                spot = MEM_AW'(MEM_BYTES - 64 + $urandom_range(0, 127));
                ins.imm_bits[MEM_AW-1:0] = spot - gpr[ins.src_reg][MEM_AW-1:0];
            end
        end else if (pick < 50) begin
            ins.op = OP_W'($urandom_range(OP_BEQ, OP_BNE));
            if ($urandom_range(0, 2) == 0)
                ins.tgt_reg = ins.src_reg;
        end else if (pick < 58) begin
            ins.op = OP_LUI;
        end else if (pick < 60) begin
            ins.op = OP_W'($urandom_range(OP_FIRST_UNUSED, OP_LAST_UNUSED));
        end else begin
            ins.op = OP_W'($urandom_range(OP_ADDI, OP_SLTIU));
        end
        return ins;
    endfunction

    // Drive one instruction beat and hold it until the unit takes it.
    task automatic send_instr(instr_t ins);
        int unsigned gap;
        if (sender_idles && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 15);
            instr_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        issued_results.push_back(execute_instr(ins));
        instr_ch.valid    <= 1'b1;
        instr_ch.op       <= ins.op;
        instr_ch.src_reg  <= ins.src_reg;
        instr_ch.tgt_reg  <= ins.tgt_reg;
        instr_ch.imm_bits <= ins.imm_bits;
        instr_ch.cur_pc   <= ins.cur_pc;
        do @(posedge i_clk); while (!instr_ch.ready);
    endtask

    task automatic issue(logic [OP_W-1:0] op, int unsigned rs, int unsigned rt,
                         logic [IMM_W-1:0] imm, logic [XLEN-1:0] pc);
        instr_t ins;
        ins.op       = op;
        ins.src_reg  = REG_W'(rs);
        ins.tgt_reg  = REG_W'(rt);
        ins.imm_bits = imm;
        ins.cur_pc   = pc;
        send_instr(ins);
    endtask

    // Drop valid and hold until every outstanding result has come back.
    task automatic wait_for_drain();
        instr_ch.valid <= 1'b0;
        while (issued_results.size() != 0 || awaited_results.size() != 0)
            @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Arithmetic, logic and compares at the immediate extremes.
    task automatic test_alu_extremes();
        issue(OP_LUI,   0, 1, 48'hFFFF_FFFF_FFFF, 64'h0);
        issue(OP_ORI,   1, 1, 48'hFFFF_FFFF_FFFF, 64'h4);
        issue(OP_ADDI,  1, 2, 48'h7FFF_FFFF_FFFF, 64'h8);
        issue(OP_ADDIU, 0, 3, 48'h8000_0000_0000, 64'hC);
        issue(OP_ANDI,  1, 4, 48'h8000_0000_0000, 64'h10);
        issue(OP_XORI,  3, 5, 48'hFFFF_FFFF_FFFF, 64'h14);
        issue(OP_SLTI,  3, 6, 48'h0,              64'h18);
        issue(OP_SLTIU, 0, 8, 48'hFFFF_FFFF_FFFF, 64'h1C);
        issue(OP_SLTIU, 1, 9, 48'h1,              64'h20);
    endtask

    // Taken and not-taken branches, with targets wrapping both ways.
    task automatic test_branches();
        issue(OP_BEQ, 1, 1, 48'h8000_0000_0000, 64'h0);
        issue(OP_BEQ, 1, 0, 48'h10,             64'h100);
        issue(OP_BNE, 1, 0, 48'h0,              64'hFFFF_FFFF_FFFF_FFF8);
    endtask

    // Byte order, sign and zero extension, and accesses wrapping past the
    // top of memory.
    task automatic test_memory();
        issue(OP_LUI, 0, 10,  48'h0000_0123_4567, 64'h40);
        issue(OP_ORI, 10, 10, 48'h0000_89AB_CDEF, 64'h44);
        issue(OP_SW,  0, 10,  48'hFFFF_FFFF_FFFC, 64'h48);
        issue(OP_LW,  0, 11,  48'hFFFF_FFFF_FFFC, 64'h4C);
        issue(OP_LH,  0, 12,  48'hFFFF_FFFF_FFFC, 64'h50);
        issue(OP_LHU, 0, 13,  48'hFFFF_FFFF_FFFC, 64'h54);
        issue(OP_LB,  0, 14,  48'hFFFF_FFFF_FFFD, 64'h58);
        issue(OP_LBU, 0, 15,  48'hFFFF_FFFF_FFFD, 64'h5C);
        issue(OP_SB,  0, 10,  48'h20,             64'h60);
        issue(OP_SH,  0, 10,  48'h21,             64'h64);
        issue(OP_LW,  0, 17,  48'h20,             64'h68);
    endtask

    // Register zero is writable; unused codes leave everything alone.
    task automatic test_register_zero_and_unused();
        issue(OP_ADDI,        1, 0, 48'h0, 64'h80);
        issue(OP_LW,          0, 18, 48'h1, 64'h84);
        issue(OP_FIRST_UNUSED, 1, 0, 48'hFFFF_FFFF_FFFF, 64'h88);
        issue(OP_LAST_UNUSED,  1, 0, 48'h8000_0000_0000, 64'h8C);
    endtask

    // Long random program; idling switches on and off in stretches.
    task automatic test_random_program(int unsigned count);
        for (int unsigned i = 0; i < count; i++) begin
            if (i % 150 == 0) begin
                sender_idles    = ($urandom_range(0, 3) != 0);
                receiver_stalls = ($urandom_range(0, 3) != 0);
            end
            if (i == count / 2)
                wait_for_drain();
            send_instr(random_instr(7));
        end
    endtask

    // Full rate on both sides, mostly over four registers: load-use and
    // store-load hazards back to back.
    task automatic test_back_to_back(int unsigned count);
        sender_idles    = 1'b0;
        receiver_stalls = 1'b0;
        for (int unsigned i = 0; i < count; i++)
            send_instr(random_instr(3));
    endtask

    // ------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------

    // Stall the result channel in random bursts while stalls are enabled.
    int unsigned stall_left;
    always @(posedge i_clk) begin
        if (stall_left == 0 && receiver_stalls && $urandom_range(0, 9) == 0)
            stall_left = $urandom_range(1, 15);
        if (stall_left != 0) begin
            result_ch.ready <= 1'b0;
            stall_left--;
        end else begin
            result_ch.ready <= 1'b1;
        end
    end

    task automatic compare_field(string name, logic [XLEN-1:0] want, logic [XLEN-1:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %h, got %h", name, want, got);
            errors++;
        end
    endtask

    // Move the prediction on each input beat, then check each result beat.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (instr_ch.valid && instr_ch.ready && issued_results.size() != 0)
                awaited_results.push_back(issued_results.pop_front());
            if (result_ch.valid && result_ch.ready) begin
                if (awaited_results.size() == 0) begin
                    $error("result beat with no instruction outstanding");
                    errors++;
                end else begin
                    head_result = awaited_results.pop_front();
                    compare_field("reg_written", head_result.reg_written,
                                  result_ch.reg_written);
                    compare_field("written_reg", head_result.written_reg,
                                  result_ch.written_reg);
                    compare_field("written_value", head_result.written_value,
                                  result_ch.written_value);
                    compare_field("branch_taken", head_result.branch_taken,
                                  result_ch.branch_taken);
                    compare_field("branch_target", head_result.branch_target,
                                  result_ch.branch_target);
                    results_checked++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial begin
        i_rst_n            <= 1'b0;
        instr_ch.valid     <= 1'b0;
        instr_ch.op        <= OP_ADDI;
        instr_ch.src_reg   <= '0;
        instr_ch.tgt_reg   <= '0;
        instr_ch.imm_bits  <= '0;
        instr_ch.cur_pc    <= '0;
        sender_idles       = 1'b1;
        receiver_stalls    = 1'b1;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // The memory clearing pass after reset holds ready low; the first
        // beat simply waits for it.
        test_alu_extremes();
        test_branches();
        test_memory();
        test_register_zero_and_unused();
        wait_for_drain();
        test_random_program(1650);
        test_back_to_back(200);

        // Hold off until the pipe is empty, then allow a few more cycles for
        // any stray beat.
        wait_for_drain();
        repeat (16) @(posedge i_clk);
        if (awaited_results.size() != 0) begin
            $error("%0d results never arrived", awaited_results.size());
            errors++;
        end

        $display("Checked %0d results: %0d loads, %0d stores, %0d taken branches,",
                 results_checked, loads_run, stores_run, branches_taken);
        $display("%0d unused codes, with random idling on both channels.", unused_run);
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run including the clearing pass.
    initial begin
        #5_000_000;
        $error("timeout: results still outstanding");
        $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/ifeu_pkg.sv
rtl/ifeu_channels.sv
rtl/immediate_format_execute_unit.sv
tb/tb_top.sv
